[rtl/core/bqb_pkg.sv]
// Package for the bracket and quote balance checker.
// Holds the shared widths, character codes, error codes and payload types.
// Depends on nothing; every other file of the core refers to it by scoped names.
`timescale 1ns / 1ps

package bqb_pkg;

  localparam int MAX_LEN   = 4096;
  localparam int IDX_W     = $clog2(MAX_LEN);
  localparam int CH_W      = 8;
  localparam int COL_W     = 12;
  localparam int CODE_W    = 4;
  localparam int DEPTH_W   = 13;

  localparam logic [IDX_W-1:0]   IDX_MAX   = IDX_W'(MAX_LEN - 1);
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

  localparam logic [CH_W-1:0] CH_DQUOTE    = 8'h22;
  localparam logic [CH_W-1:0] CH_SQUOTE    = 8'h27;
  localparam logic [CH_W-1:0] CH_BACKSLASH = 8'h5C;
  localparam logic [CH_W-1:0] CH_LPAREN    = 8'h28;
  localparam logic [CH_W-1:0] CH_RPAREN    = 8'h29;
  localparam logic [CH_W-1:0] CH_LBRACKET  = 8'h5B;
  localparam logic [CH_W-1:0] CH_RBRACKET  = 8'h5D;
  localparam logic [CH_W-1:0] CH_LBRACE    = 8'h7B;
  localparam logic [CH_W-1:0] CH_RBRACE    = 8'h7D;
  localparam logic [CH_W-1:0] CH_COLON     = 8'h3A;
  localparam logic [CH_W-1:0] CH_SPACE     = 8'h20;
  localparam logic [CH_W-1:0] CH_D         = 8'h64;
  localparam logic [CH_W-1:0] CH_E         = 8'h65;
  localparam logic [CH_W-1:0] CH_F         = 8'h66;

  typedef enum logic [CODE_W-1:0] {
    ERR_NONE          = 4'd0,
    ERR_PAREN_UNDER   = 4'd1,
    ERR_BRACKET_UNDER = 4'd2,
    ERR_BRACE_UNDER   = 4'd3,
    ERR_OPEN_STRING   = 4'd4,
    ERR_PAREN_OPEN    = 4'd5,
    ERR_BRACKET_OPEN  = 4'd6,
    ERR_BRACE_OPEN    = 4'd7,
    ERR_DEF_NO_COLON  = 4'd8
  } err_code_t;

  typedef enum logic [1:0] {
    KW_NONE = 2'd0,
    KW_D    = 2'd1,
    KW_DE   = 2'd2,
    KW_DEF  = 2'd3
  } kw_state_t;

  typedef struct packed {
    logic [CH_W-1:0] ch;
    logic            last;
  } item_t;

  typedef struct packed {
    err_code_t        code;
    logic [COL_W-1:0] column;
  } result_t;

endpackage

[rtl/core/bqb_if.sv]
// Channel interfaces for the bracket and quote balance checker.
// Each carries valid, ready and the payload of one request; depends on bqb_pkg.
`timescale 1ns / 1ps

interface bqb_char_if;
  logic                     valid;
  logic                     ready;
  logic [bqb_pkg::CH_W-1:0] ch;
  logic                     last;

  modport source (output valid, output ch, output last, input ready);
  modport sink (input valid, input ch, input last, output ready);
endinterface

interface bqb_result_if;
  logic                       valid;
  logic                       ready;
  logic [bqb_pkg::CODE_W-1:0] error_code;
  logic [bqb_pkg::COL_W-1:0]  error_column;

  modport source (output valid, output error_code, output error_column, input ready);
  modport sink (input valid, input error_code, input error_column, output ready);
endinterface

[rtl/core/bqb_in_stage.sv]
// Input register of the checker: captures one character request per cycle while the held one is consumed or absent.
// Depends on bqb_pkg and bqb_char_if.
`timescale 1ns / 1ps

module bqb_in_stage (
  input  logic           clk,
  input  logic           rst,
  bqb_char_if.sink       chars,
  input  logic           consume,
  output logic           valid,
  output bqb_pkg::item_t item
);

  assign chars.ready = !valid || consume;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (chars.ready) begin
      valid <= chars.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (chars.ready && chars.valid) begin
      item.ch   <= chars.ch;
      item.last <= chars.last;
    end
  end

endmodule

[rtl/core/bqb_scan.sv]
// Scan stage: updates depth, string, keyword and error state for one character
// and forms the verdict on the final character. Depends on bqb_pkg.
`timescale 1ns / 1ps

module bqb_scan (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  input  bqb_pkg::item_t   item,
  input  logic             slot_free,
  output logic             consume,
  output logic             res_valid,
  output bqb_pkg::result_t res
);

  logic [bqb_pkg::DEPTH_W-1:0] paren_depth, paren_depth_next;
  logic [bqb_pkg::DEPTH_W-1:0] bracket_depth, bracket_depth_next;
  logic [bqb_pkg::DEPTH_W-1:0] brace_depth, brace_depth_next;
  logic                        inside_string, inside_string_next;
  logic                        quote_is_double, quote_is_double_next;
  logic                        prev_was_backslash;
  logic [bqb_pkg::IDX_W-1:0]   char_index, char_index_next;
  bqb_pkg::err_code_t          latched_error, latched_error_next;
  logic [bqb_pkg::COL_W-1:0]   latched_column, latched_column_next;
  bqb_pkg::kw_state_t          keyword_progress, keyword_progress_next;
  logic                        keyword_seen, keyword_seen_next;
  logic                        colon_seen, colon_seen_next;
  logic [bqb_pkg::CH_W-1:0]    closer;
  logic [bqb_pkg::CH_W-1:0]    c;
  logic [bqb_pkg::COL_W-1:0]   cur_column;

  assign consume   = item_valid && (!item.last || slot_free);
  assign res_valid = consume && item.last;
  assign c         = item.ch;
  assign closer    = quote_is_double ? bqb_pkg::CH_DQUOTE : bqb_pkg::CH_SQUOTE;
  assign cur_column = bqb_pkg::COL_W'(char_index);

  always_comb begin
    paren_depth_next      = paren_depth;
    bracket_depth_next    = bracket_depth;
    brace_depth_next      = brace_depth;
    inside_string_next    = inside_string;
    quote_is_double_next  = quote_is_double;
    latched_error_next    = latched_error;
    latched_column_next   = latched_column;
    keyword_progress_next = keyword_progress;
    keyword_seen_next     = keyword_seen;
    colon_seen_next       = colon_seen;
    char_index_next       = (char_index < bqb_pkg::IDX_MAX) ? char_index + 1'b1 : char_index;

    if (latched_error == bqb_pkg::ERR_NONE) begin
      if (c == bqb_pkg::CH_COLON) begin
        colon_seen_next = 1'b1;
      end
      if (keyword_progress == bqb_pkg::KW_DEF && c == bqb_pkg::CH_SPACE) begin
        keyword_seen_next     = 1'b1;
        keyword_progress_next = bqb_pkg::KW_NONE;
      end else if (keyword_progress == bqb_pkg::KW_D && c == bqb_pkg::CH_E) begin
        keyword_progress_next = bqb_pkg::KW_DE;
      end else if (keyword_progress == bqb_pkg::KW_DE && c == bqb_pkg::CH_F) begin
        keyword_progress_next = bqb_pkg::KW_DEF;
      end else begin
        keyword_progress_next = (c == bqb_pkg::CH_D) ? bqb_pkg::KW_D : bqb_pkg::KW_NONE;
      end

      if (!inside_string) begin
        case (c)
          bqb_pkg::CH_DQUOTE, bqb_pkg::CH_SQUOTE: begin
            inside_string_next   = 1'b1;
            quote_is_double_next = (c == bqb_pkg::CH_DQUOTE);
          end
          bqb_pkg::CH_LPAREN: begin
            if (paren_depth != bqb_pkg::DEPTH_MAX) paren_depth_next = paren_depth + 1'b1;
          end
          bqb_pkg::CH_RPAREN: begin
            if (paren_depth == '0) begin
              latched_error_next  = bqb_pkg::ERR_PAREN_UNDER;
              latched_column_next = cur_column;
            end else begin
              paren_depth_next = paren_depth - 1'b1;
            end
          end
          bqb_pkg::CH_LBRACKET: begin
            if (bracket_depth != bqb_pkg::DEPTH_MAX) bracket_depth_next = bracket_depth + 1'b1;
          end
          bqb_pkg::CH_RBRACKET: begin
            if (bracket_depth == '0) begin
              latched_error_next  = bqb_pkg::ERR_BRACKET_UNDER;
              latched_column_next = cur_column;
            end else begin
              bracket_depth_next = bracket_depth - 1'b1;
            end
          end
          bqb_pkg::CH_LBRACE: begin
            if (brace_depth != bqb_pkg::DEPTH_MAX) brace_depth_next = brace_depth + 1'b1;
          end
          bqb_pkg::CH_RBRACE: begin
            if (brace_depth == '0) begin
              latched_error_next  = bqb_pkg::ERR_BRACE_UNDER;
              latched_column_next = cur_column;
            end else begin
              brace_depth_next = brace_depth - 1'b1;
            end
          end
          default: begin
          end
        endcase
      end else if (c == closer && !prev_was_backslash) begin
        inside_string_next = 1'b0;
      end
    end
  end

  always_comb begin
    res.code   = bqb_pkg::ERR_NONE;
    res.column = '0;
    if (latched_error_next != bqb_pkg::ERR_NONE) begin
      res.code   = latched_error_next;
      res.column = latched_column_next;
    end else if (inside_string_next) begin
      res.code = bqb_pkg::ERR_OPEN_STRING;
    end else if (paren_depth_next != '0) begin
      res.code = bqb_pkg::ERR_PAREN_OPEN;
    end else if (bracket_depth_next != '0) begin
      res.code = bqb_pkg::ERR_BRACKET_OPEN;
    end else if (brace_depth_next != '0) begin
      res.code = bqb_pkg::ERR_BRACE_OPEN;
    end else if (keyword_seen_next && !colon_seen_next) begin
      res.code = bqb_pkg::ERR_DEF_NO_COLON;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || res_valid) begin
      paren_depth        <= '0;
      bracket_depth      <= '0;
      brace_depth        <= '0;
      inside_string      <= 1'b0;
      quote_is_double    <= 1'b0;
      prev_was_backslash <= 1'b0;
      char_index         <= '0;
      latched_error      <= bqb_pkg::ERR_NONE;
      latched_column     <= '0;
      keyword_progress   <= bqb_pkg::KW_NONE;
      keyword_seen       <= 1'b0;
      colon_seen         <= 1'b0;
    end else if (consume) begin
      paren_depth        <= paren_depth_next;
      bracket_depth      <= bracket_depth_next;
      brace_depth        <= brace_depth_next;
      inside_string      <= inside_string_next;
      quote_is_double    <= quote_is_double_next;
      prev_was_backslash <= (c == bqb_pkg::CH_BACKSLASH);
      char_index         <= char_index_next;
      latched_error      <= latched_error_next;
      latched_column     <= latched_column_next;
      keyword_progress   <= keyword_progress_next;
      keyword_seen       <= keyword_seen_next;
      colon_seen         <= colon_seen_next;
    end
  end

endmodule

[rtl/core/bqb_out_stage.sv]
// Result register of the checker: holds one verdict until the sink takes it.
// Depends on bqb_pkg and bqb_result_if.
`timescale 1ns / 1ps

module bqb_out_stage (
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  bqb_pkg::result_t res,
  output logic             slot_free,
  bqb_result_if.source     results
);

  bqb_pkg::result_t held;

  assign slot_free            = !results.valid || results.ready;
  assign results.error_code   = held.code;
  assign results.error_column = held.column;

  always_ff @(posedge clk) begin
    if (rst) begin
      results.valid <= 1'b0;
    end else if (load) begin
      results.valid <= 1'b1;
    end else if (results.ready) begin
      results.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      held <= res;
    end
  end

endmodule

[rtl/core/bracket_quote_balance_checker_core.sv]
// Bracket and quote balance checker, top level.
// The input register holds a final character until its verdict loads the result register.
// Throughput: one character per cycle; only a stalled verdict holds back the next final one.
// Reset (synchronous, active high) clears all counters and flags and empties both registers.
// After each verdict the checker returns to its reset state for the next script.
`timescale 1ns / 1ps

module bracket_quote_balance_checker_core (
  input  logic         clk,
  input  logic         rst,
  bqb_char_if.sink     items,
  bqb_result_if.source results
);

  logic             item_valid;
  bqb_pkg::item_t   item;
  logic             consume;
  logic             res_valid;
  bqb_pkg::result_t res;
  logic             slot_free;

  bqb_in_stage u_in (
    .clk     (clk),
    .rst     (rst),
    .chars   (items),
    .consume (consume),
    .valid   (item_valid),
    .item    (item)
  );

  bqb_scan u_scan (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .slot_free  (slot_free),
    .consume    (consume),
    .res_valid  (res_valid),
    .res        (res)
  );

  bqb_out_stage u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .slot_free (slot_free),
    .results   (results)
  );

endmodule

[sim/tb_bracket_quote_balance_checker_core.sv]
// Self-checking testbench for bracket_quote_balance_checker_core.
// It streams scripts through the character channel, predicts each verdict and checks it.
// Depends on bqb_pkg, the bqb_char_if and bqb_result_if interfaces and the core.
`timescale 1ns / 1ps

module tb_bracket_quote_balance_checker_core;

  localparam int RESET_CYCLES = 11;
  localparam int IDLE_LIMIT   = 2000;
  localparam int LONG_HOLD    = 400;
  localparam int RANDOM_CHARS = 1830;

  typedef struct {
    bqb_pkg::item_t it;
    bit             drain;
  } pending_char_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #2 clk = ~clk;

  bqb_char_if   char_bus ();
  bqb_result_if verdict_bus ();

  bracket_quote_balance_checker_core i_dut (
    .clk     (clk),
    .rst     (rst),
    .items   (char_bus),
    .results (verdict_bus)
  );

  pending_char_t             char_q [$];
  logic [bqb_pkg::CH_W-1:0]  script_buf [$];
  bqb_pkg::result_t          verdict_q [$];

  logic [bqb_pkg::DEPTH_W-1:0] sc_depth [3];
  logic                        sc_in_str;
  logic                        sc_dq;
  logic                        sc_bs;
  logic                        sc_kw_seen;
  logic                        sc_colon;
  logic [bqb_pkg::IDX_W-1:0]   sc_idx;
  bqb_pkg::err_code_t          sc_err;
  logic [bqb_pkg::COL_W-1:0]   sc_col;
  bqb_pkg::kw_state_t          sc_kw;

  int fails = 0;
  int scripts_sent = 0;
  int chars_sent = 0;
  int verdicts_seen = 0;
  int idle_cycles = 0;
  int drains = 0;
  int code_tally [16];
  int burst_left = 0;
  int gap_left = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  int stall_pct = 0;
  int pattern_left = 0;
  bit char_taken = 1'b0;
  pending_char_t next_char;
  bqb_pkg::result_t oldest_verdict;

  task automatic clear_script();
    for (int k = 0; k < 3; k++) sc_depth[k] = '0;
    sc_in_str = 1'b0;
    sc_dq = 1'b0;
    sc_bs = 1'b0;
    sc_kw_seen = 1'b0;
    sc_colon = 1'b0;
    sc_idx = '0;
    sc_err = bqb_pkg::ERR_NONE;
    sc_col = '0;
    sc_kw = bqb_pkg::KW_NONE;
  endtask

  task automatic add_char(input logic [bqb_pkg::CH_W-1:0] c);
    script_buf = {script_buf, c};
  endtask

  task automatic advance_script(input logic [bqb_pkg::CH_W-1:0] c, input logic is_last);
    int k;
    bit closing;
    bqb_pkg::err_code_t under;
    bqb_pkg::result_t v;
    k = -1;
    closing = 1'b0;
    under = bqb_pkg::ERR_NONE;
    if (sc_err == bqb_pkg::ERR_NONE) begin
      if (c == bqb_pkg::CH_COLON) sc_colon = 1'b1;
      if (sc_kw == bqb_pkg::KW_DEF && c == bqb_pkg::CH_SPACE) begin
        sc_kw_seen = 1'b1;
        sc_kw = bqb_pkg::KW_NONE;
      end else if (sc_kw == bqb_pkg::KW_D && c == bqb_pkg::CH_E) begin
        sc_kw = bqb_pkg::KW_DE;
      end else if (sc_kw == bqb_pkg::KW_DE && c == bqb_pkg::CH_F) begin
        sc_kw = bqb_pkg::KW_DEF;
      end else begin
        sc_kw = (c == bqb_pkg::CH_D) ? bqb_pkg::KW_D : bqb_pkg::KW_NONE;
      end
      if (sc_in_str) begin
        if (c == (sc_dq ? bqb_pkg::CH_DQUOTE : bqb_pkg::CH_SQUOTE) && !sc_bs) sc_in_str = 1'b0;
      end else begin
        case (c)
          bqb_pkg::CH_DQUOTE, bqb_pkg::CH_SQUOTE: begin
            sc_in_str = 1'b1;
            sc_dq = (c == bqb_pkg::CH_DQUOTE);
          end
          bqb_pkg::CH_LPAREN: k = 0;
          bqb_pkg::CH_LBRACKET: k = 1;
          bqb_pkg::CH_LBRACE: k = 2;
          bqb_pkg::CH_RPAREN: begin
            k = 0;
            closing = 1'b1;
            under = bqb_pkg::ERR_PAREN_UNDER;
          end
          bqb_pkg::CH_RBRACKET: begin
            k = 1;
            closing = 1'b1;
            under = bqb_pkg::ERR_BRACKET_UNDER;
          end
          bqb_pkg::CH_RBRACE: begin
            k = 2;
            closing = 1'b1;
            under = bqb_pkg::ERR_BRACE_UNDER;
          end
          default: ;
        endcase
        if (k >= 0) begin
          if (!closing) begin
            if (sc_depth[k] != bqb_pkg::DEPTH_MAX) sc_depth[k]++;
          end else if (sc_depth[k] == '0) begin
            sc_err = under;
            sc_col = sc_idx;
          end else begin
            sc_depth[k]--;
          end
        end
      end
    end
    sc_bs = (c == bqb_pkg::CH_BACKSLASH);
    if (sc_idx != bqb_pkg::IDX_MAX) sc_idx++;
    if (is_last) begin
      v.column = '0;
      if (sc_err != bqb_pkg::ERR_NONE) begin
        v.code = sc_err;
        v.column = sc_col;
      end else if (sc_in_str) begin
        v.code = bqb_pkg::ERR_OPEN_STRING;
      end else if (sc_depth[0] != '0) begin
        v.code = bqb_pkg::ERR_PAREN_OPEN;
      end else if (sc_depth[1] != '0) begin
        v.code = bqb_pkg::ERR_BRACKET_OPEN;
      end else if (sc_depth[2] != '0) begin
        v.code = bqb_pkg::ERR_BRACE_OPEN;
      end else if (sc_kw_seen && !sc_colon) begin
        v.code = bqb_pkg::ERR_DEF_NO_COLON;
      end else begin
        v.code = bqb_pkg::ERR_NONE;
      end
      verdict_q = {verdict_q, v};
      clear_script();
    end
  endtask

  task automatic emit_script(input bit drain);
    pending_char_t p;
    for (int i = 0; i < script_buf.size(); i++) begin
      p.it.ch = script_buf[i];
      p.it.last = (i == script_buf.size() - 1);
      p.drain = drain && (i == 0);
      char_q = {char_q, p};
    end
    chars_sent += script_buf.size();
    scripts_sent++;
    script_buf.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) add_char(s[i]);
    emit_script(1'b0);
  endtask

  function automatic logic [bqb_pkg::CH_W-1:0] pick_special();
    case ($urandom_range(0, 14))
      0: return bqb_pkg::CH_DQUOTE;
      1: return bqb_pkg::CH_SQUOTE;
      2: return bqb_pkg::CH_BACKSLASH;
      3: return bqb_pkg::CH_LPAREN;
      4: return bqb_pkg::CH_RPAREN;
      5: return bqb_pkg::CH_LBRACKET;
      6: return bqb_pkg::CH_RBRACKET;
      7: return bqb_pkg::CH_LBRACE;
      8: return bqb_pkg::CH_RBRACE;
      9: return bqb_pkg::CH_COLON;
      10: return bqb_pkg::CH_SPACE;
      11: return bqb_pkg::CH_D;
      12: return bqb_pkg::CH_E;
      13: return bqb_pkg::CH_F;
      default: return bqb_pkg::CH_W'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic logic [bqb_pkg::CH_W-1:0] opener_of(input int k);
    return (k == 0) ? bqb_pkg::CH_LPAREN : (k == 1) ? bqb_pkg::CH_LBRACKET : bqb_pkg::CH_LBRACE;
  endfunction

  function automatic logic [bqb_pkg::CH_W-1:0] closer_of(input int k);
    return (k == 0) ? bqb_pkg::CH_RPAREN : (k == 1) ? bqb_pkg::CH_RBRACKET : bqb_pkg::CH_RBRACE;
  endfunction

  task automatic build_wellformed();
    logic [bqb_pkg::CH_W-1:0] closers [$];
    logic [bqb_pkg::CH_W-1:0] q;
    int tokens;
    int k;
    tokens = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 10);
    for (int n = 0; n < tokens; n++) begin
      case ($urandom_range(0, 9))
        0, 1: begin
          k = $urandom_range(0, 2);
          add_char(opener_of(k));
          closers = {closers, closer_of(k)};
        end
        2, 3: begin
          if (closers.size() != 0) add_char(closers.pop_back());
          else add_char(bqb_pkg::CH_W'("a") + bqb_pkg::CH_W'($urandom_range(0, 25)));
        end
        4: begin
          q = $urandom_range(0, 1) ? bqb_pkg::CH_DQUOTE : bqb_pkg::CH_SQUOTE;
          add_char(q);
          repeat ($urandom_range(0, 6)) begin
            if ($urandom_range(0, 4) == 0) add_char(bqb_pkg::CH_BACKSLASH);
            add_char(($urandom_range(0, 2) == 0) ? pick_special() :
                     bqb_pkg::CH_W'($urandom_range(0, 255)));
          end
          if ($urandom_range(0, 9) != 0) add_char(q);
        end
        5: begin
          add_char(bqb_pkg::CH_D);
          add_char(bqb_pkg::CH_E);
          add_char(bqb_pkg::CH_F);
          add_char(bqb_pkg::CH_SPACE);
        end
        6: add_char(bqb_pkg::CH_COLON);
        default: begin
          if ($urandom_range(0, 7) == 0) add_char(bqb_pkg::CH_W'($urandom_range(0, 255)));
          else add_char(bqb_pkg::CH_W'("a") + bqb_pkg::CH_W'($urandom_range(0, 25)));
        end
      endcase
    end
    while (closers.size() != 0) add_char(closers.pop_back());
    if ($urandom_range(0, 3) == 0)
      script_buf[$urandom_range(0, script_buf.size() - 1)] = pick_special();
  endtask

  // Driver: new requests are presented at the falling edge, in bursts with gaps.
  always @(negedge clk) begin
    if (rst) begin
      char_bus.valid <= 1'b0;
    end else if (!char_bus.valid || char_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        char_bus.valid <= 1'b0;
      end else if (char_q.size() != 0 && !(char_q[0].drain && verdict_q.size() != 0)) begin
        next_char = char_q.pop_front();
        if (next_char.drain) drains++;
        char_bus.valid <= 1'b1;
        char_bus.ch <= next_char.it.ch;
        char_bus.last <= next_char.it.last;
        if (burst_left <= 1) begin
          burst_left = $urandom_range(1, 40);
          if ($urandom_range(0, 1) == 0) gap_left = 0;
          else if ($urandom_range(0, 9) == 0) gap_left = $urandom_range(10, 30);
          else gap_left = $urandom_range(1, 8);
        end else begin
          burst_left--;
        end
      end else begin
        char_bus.valid <= 1'b0;
      end
    end
  end

  // Receiver: random stall patterns, plus one long hold-off.
  always @(negedge clk) begin
    if (rst) begin
      verdict_bus.ready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      verdict_bus.ready <= 1'b0;
    end else if (!hold_done && verdicts_seen >= 40) begin
      hold_done = 1'b1;
      hold_left = LONG_HOLD - 1;
      verdict_bus.ready <= 1'b0;
    end else begin
      if (pattern_left == 0) begin
        case ($urandom_range(0, 3))
          0: stall_pct = 0;
          1: stall_pct = 25;
          2: stall_pct = 60;
          default: stall_pct = 90;
        endcase
        pattern_left = $urandom_range(8, 80);
      end
      pattern_left--;
      verdict_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  // Monitor: predicts on each accepted character and checks each accepted verdict.
  always @(posedge clk) begin
    if (rst) begin
      char_taken <= 1'b0;
      idle_cycles <= 0;
    end else begin
      char_taken <= char_bus.valid && char_bus.ready;
      if ((char_bus.valid && char_bus.ready) || (verdict_bus.valid && verdict_bus.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (verdict_bus.valid && verdict_bus.ready) begin
        verdicts_seen <= verdicts_seen + 1;
        if (verdict_q.size() == 0) begin
          $error("Unexpected verdict: error_code %0d, error_column %0d",
                 verdict_bus.error_code, verdict_bus.error_column);
          fails++;
        end else begin
          oldest_verdict = verdict_q.pop_front();
          code_tally[oldest_verdict.code]++;
          if (verdict_bus.error_code !== oldest_verdict.code) begin
            $error("error_code: expected %0d, actual %0d",
                   oldest_verdict.code, verdict_bus.error_code);
            fails++;
          end
          if (verdict_bus.error_column !== oldest_verdict.column) begin
            $error("error_column: expected %0d, actual %0d",
                   oldest_verdict.column, verdict_bus.error_column);
            fails++;
          end
        end
      end
      if (char_bus.valid && char_bus.ready) advance_script(char_bus.ch, char_bus.last);
    end
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("Timeout: no request moved for %0d cycles", IDLE_LIMIT);
    $display("Verification failed");
    $finish;
  end

  initial begin
    int random_chars;
    bit first;
    char_bus.valid = 1'b0;
    char_bus.ch = '0;
    char_bus.last = 1'b0;
    verdict_bus.ready = 1'b0;
    for (int i = 0; i < 16; i++) code_tally[i] = 0;
    clear_script();

    add_text(")");
    add_text("a]");
    add_text("}");
    add_text("'");
    add_text("(");
    add_text("[");
    add_text("{");
    add_text("def ");
    add_text("\"\\\"");
    add_text("'\"'");
    add_text(")(");
    add_char(8'h00);
    add_char(8'hFF);
    emit_script(1'b0);

    random_chars = 0;
    first = 1'b1;
    while (random_chars < RANDOM_CHARS) begin
      if ($urandom_range(0, 3) == 0) begin
        repeat ($urandom_range(1, 20)) add_char(pick_special());
      end else begin
        build_wellformed();
      end
      random_chars += script_buf.size();
      emit_script(first || $urandom_range(0, 24) == 0);
      first = 1'b0;
    end

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    while (char_q.size() != 0 || char_bus.valid || verdict_q.size() != 0) @(negedge clk);
    repeat (8) @(posedge clk);

    $display("Sent %0d scripts (%0d characters); %0d verdicts checked, %0d-cycle hold-off, %0d drains.",
             scripts_sent, chars_sent, verdicts_seen, LONG_HOLD, drains);
    $display("Verdicts: ok %0d, underflow %0d, open string %0d, unbalanced %0d, def %0d.",
             code_tally[bqb_pkg::ERR_NONE],
             code_tally[bqb_pkg::ERR_PAREN_UNDER] + code_tally[bqb_pkg::ERR_BRACKET_UNDER] +
             code_tally[bqb_pkg::ERR_BRACE_UNDER],
             code_tally[bqb_pkg::ERR_OPEN_STRING],
             code_tally[bqb_pkg::ERR_PAREN_OPEN] + code_tally[bqb_pkg::ERR_BRACKET_OPEN] +
             code_tally[bqb_pkg::ERR_BRACE_OPEN],
             code_tally[bqb_pkg::ERR_DEF_NO_COLON]);
    if (fails == 0 && verdict_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/bqb_pkg.sv
rtl/core/bqb_if.sv
rtl/core/bqb_in_stage.sv
rtl/core/bqb_scan.sv
rtl/core/bqb_out_stage.sv
rtl/core/bracket_quote_balance_checker_core.sv
sim/tb_bracket_quote_balance_checker_core.sv
